[design/i2cm_pkg.sv]
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by i2cm_front, i2cm_back and i2c_master_bit_engine.
package i2cm_pkg;

    localparam int DATA_W      = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_NONE  = 3'd0;
    localparam cmd_t CMD_START = 3'd1;
    localparam cmd_t CMD_STOP  = 3'd2;
    localparam cmd_t CMD_WRITE = 3'd3;
    localparam cmd_t CMD_READ  = 3'd4;

    // configuration register indexes
    localparam logic CFG_HALF_PERIOD   = 1'b0;
    localparam logic CFG_STRETCH_LIMIT = 1'b1;

    localparam logic [7:0] HALF_PERIOD_RESET   = 8'd8;
    localparam logic [7:0] STRETCH_LIMIT_RESET = 8'd255;
    localparam logic [3:0] BYTE_BITS           = 4'd8;

    // one classified tick waiting for the executor
    typedef struct packed {
        cmd_t              cmd;
        logic [DATA_W-1:0] write_data;
        logic              ack_to_send;
        logic              scl_in;
        logic              sda_in;
    } item_t;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_SETUP      = 7'b0000010,
        PH_HIGH       = 7'b0000100,
        PH_POST       = 7'b0001000,
        PH_START_HOLD = 7'b0010000,
        PH_STOP_HOLD  = 7'b0100000,
        PH_TAIL       = 7'b1000000
    } phase_t;

endpackage

[design/i2cm_front.sv]
// Front end: accepts tick requests, decodes the operation code and queues them.
// Depends on i2cm_pkg.
module i2cm_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [2:0] operation, [10:3] write_data, [11] ack_to_send, [12] scl_in,
    // [13] sda_in, [15:14] zero
    input  logic [i2cm_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               q_valid,
    input  logic                               q_ready,
    output i2cm_pkg::item_t                    q_item
);
    import i2cm_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;
    item_t             item_in;
    logic [2:0]        op;
    logic              push, pop;

    // unused codes fold into a plain tick
    always_comb begin
        op                  = s_tdata[2:0];
        item_in.cmd         = (op inside {[CMD_START:CMD_READ]}) ? op : CMD_NONE;
        item_in.write_data  = s_tdata[10:3];
        item_in.ack_to_send = s_tdata[11];
        item_in.scl_in      = s_tdata[12];
        item_in.sda_in      = s_tdata[13];
    end

    assign s_tready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

[design/i2cm_back.sv]
// Back end: bit-level I2C sequencer, configuration registers and result register.
// Depends on i2cm_pkg.
module i2cm_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic                               cfg_index,
    input  logic [i2cm_pkg::DATA_W-1:0]        cfg_data,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  i2cm_pkg::item_t                    q_item,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
    // [4] ack_received, [12:5] read_data, [13] timeout, [15:14] zero
    output logic [i2cm_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import i2cm_pkg::*;

    logic [DATA_W-1:0] half_reg, stretch_reg;

    phase_t            phase_reg, phase_next;
    cmd_t              cmd_reg, cmd_next;
    logic [3:0]        bit_reg, bit_next;
    logic [DATA_W-1:0] shift_reg, shift_next;
    logic [DATA_W-1:0] delay_reg, delay_next;
    logic [DATA_W-1:0] stretch_cnt_reg, stretch_cnt_next;
    logic              ack_hold_reg, ack_hold_next;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [DATA_W-1:0] delay_inc, delay_after, stretch_inc;
    logic              elapsed;
    logic              done, tmo, ackr, busy, scl_o, sda_o, sda_lvl;
    logic [DATA_W-1:0] rd;
    logic              pop;

    assign q_ready  = !out_valid_reg || m_tready;
    assign pop      = q_valid && q_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg    <= HALF_PERIOD_RESET;
            stretch_reg <= STRETCH_LIMIT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_HALF_PERIOD) begin
                half_reg <= cfg_data;
            end else begin
                stretch_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        cmd_next         = cmd_reg;
        bit_next         = bit_reg;
        shift_next       = shift_reg;
        delay_next       = delay_reg;
        stretch_cnt_next = stretch_cnt_reg;
        ack_hold_next    = ack_hold_reg;
        done             = 1'b0;
        tmo              = 1'b0;
        ackr             = 1'b0;
        rd               = '0;

        // a half period of zero still ends after one tick
        delay_inc   = delay_reg + 8'd1;
        elapsed     = (delay_inc >= half_reg);
        delay_after = elapsed ? '0 : delay_inc;
        stretch_inc = stretch_cnt_reg + 8'd1;

        case (phase_reg)
            PH_SETUP: begin
                delay_next = delay_after;
                if (elapsed) begin
                    phase_next       = PH_HIGH;
                    stretch_cnt_next = '0;
                end
            end
            PH_HIGH: begin
                if (q_item.scl_in) begin
                    phase_next = PH_POST;
                    delay_next = '0;
                end else begin
                    stretch_cnt_next = stretch_inc;
                    if (stretch_inc >= stretch_reg) begin
                        // stretch timeout: abort and release the bus
                        done = 1'b1;
                        tmo  = 1'b1;
                        if (cmd_reg == CMD_WRITE) begin
                            ackr          = 1'b1;
                            ack_hold_next = 1'b1;
                        end
                        shift_next = '0;
                        cmd_next   = CMD_NONE;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_POST: begin
                delay_next = delay_after;
                if (elapsed) begin
                    case (cmd_reg)
                        CMD_START: phase_next = PH_START_HOLD;
                        CMD_STOP:  phase_next = PH_STOP_HOLD;
                        CMD_WRITE, CMD_READ: begin
                            if (bit_reg < BYTE_BITS) begin
                                shift_next = {shift_reg[DATA_W-2:0],
                                              (cmd_reg == CMD_READ) && q_item.sda_in};
                                bit_next   = bit_reg + 4'd1;
                                phase_next = PH_SETUP;
                            end else begin
                                if (cmd_reg == CMD_WRITE) begin
                                    ack_hold_next = q_item.sda_in;
                                end
                                phase_next = PH_TAIL;
                            end
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
            PH_START_HOLD, PH_STOP_HOLD, PH_TAIL: begin
                delay_next = delay_after;
                if (elapsed) begin
                    done       = 1'b1;
                    ackr       = (cmd_reg == CMD_WRITE) && ack_hold_reg;
                    rd         = (cmd_reg == CMD_READ) ? shift_reg : '0;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (q_item.cmd != CMD_NONE) begin
                    cmd_next         = q_item.cmd;
                    bit_next         = '0;
                    delay_next       = '0;
                    stretch_cnt_next = '0;
                    shift_next       = (q_item.cmd == CMD_WRITE) ? q_item.write_data : '0;
                    ack_hold_next    = (q_item.cmd == CMD_READ) && q_item.ack_to_send;
                    phase_next       = PH_SETUP;
                end
            end
        endcase

        case (cmd_next)
            CMD_STOP:  sda_lvl = 1'b0;
            CMD_WRITE: sda_lvl = (bit_next < BYTE_BITS) ? shift_next[DATA_W-1] : 1'b1;
            CMD_READ:  sda_lvl = (bit_next < BYTE_BITS) ? 1'b1 : ack_hold_next;
            default:   sda_lvl = 1'b1;
        endcase

        case (phase_next)
            PH_SETUP, PH_TAIL: begin
                scl_o = 1'b0;
                sda_o = sda_lvl;
            end
            PH_HIGH, PH_POST: begin
                scl_o = 1'b1;
                sda_o = sda_lvl;
            end
            PH_START_HOLD: begin
                scl_o = 1'b1;
                sda_o = 1'b0;
            end
            PH_STOP_HOLD: begin
                scl_o = 1'b1;
                sda_o = 1'b1;
            end
            default: begin
                // idle levels follow the last finished command
                case (cmd_next)
                    CMD_START: begin
                        scl_o = 1'b0;
                        sda_o = 1'b0;
                    end
                    CMD_WRITE: begin
                        scl_o = 1'b0;
                        sda_o = 1'b1;
                    end
                    CMD_READ: begin
                        scl_o = 1'b0;
                        sda_o = ack_hold_next;
                    end
                    default: begin
                        scl_o = 1'b1;
                        sda_o = 1'b1;
                    end
                endcase
            end
        endcase

        busy = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            cmd_reg         <= CMD_NONE;
            bit_reg         <= '0;
            shift_reg       <= '0;
            delay_reg       <= '0;
            stretch_cnt_reg <= '0;
            ack_hold_reg    <= 1'b0;
        end else if (pop) begin
            phase_reg       <= phase_next;
            cmd_reg         <= cmd_next;
            bit_reg         <= bit_next;
            shift_reg       <= shift_next;
            delay_reg       <= delay_next;
            stretch_cnt_reg <= stretch_cnt_next;
            ack_hold_reg    <= ack_hold_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= {2'b00, tmo, rd, ackr, done, busy, sda_o, scl_o};
        end
    end

endmodule

[design/i2c_master_bit_engine.sv]
// Top level of the I2C master bit engine: front end, request queue, sequencer.
// Depends on i2cm_pkg, i2cm_front and i2cm_back.
//
// Every accepted request is one timebase tick and yields exactly one result, in
// order. The engine sustains one request per clock while the result side is not
// stalled; a result passes through the two-entry queue and then the sequencer's
// result register, and the queue absorbs up to two requests while the result
// side is stalled. Rate is set by the sequencer, which updates the whole bit
// state once per tick. Registers: index 0 half period in ticks (reset 8), index 1
// stretch limit (reset 255); write them only while no request is in flight.
// cfg_ready is always high.
module i2c_master_bit_engine (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [2:0] operation, [10:3] write_data, [11] ack_to_send, [12] scl_in,
    // [13] sda_in, [15:14] zero
    input  logic [i2cm_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
    // [4] ack_received, [12:5] read_data, [13] timeout, [15:14] zero
    output logic [i2cm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [i2cm_pkg::DATA_W-1:0]        cfg_data
);
    import i2cm_pkg::*;

    logic  q_valid, q_ready;
    item_t q_item;

    assign cfg_ready = 1'b1;

    i2cm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    i2cm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a finished command always leaves the engine idle
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done and busy reported together");

    // result fields are zero off the done tick
    a_timeout_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[13] || m_tdata[4]) |-> m_tdata[3])
        else $error("timeout or ack without done");

    a_read_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[12:5] != '0) |-> m_tdata[3])
        else $error("read data without done");

    // every request taken from the queue produces a result
    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready |=> m_tvalid)
        else $error("queued request produced no result");

endmodule
